// ===== src/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types, codes and helper functions for the SQL literal parser.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

    // Column type codes
    localparam logic [2:0] COL_INT   = 3'd0;
    localparam logic [2:0] COL_DEC   = 3'd1;
    localparam logic [2:0] COL_BOOL  = 3'd2;
    localparam logic [2:0] COL_DATE  = 3'd3;
    localparam logic [2:0] COL_DTIME = 3'd4;

    // Config register indexes
    localparam logic CFG_COL_TYPE  = 1'b0;
    localparam logic CFG_DEC_SCALE = 1'b1;

    // Number reader phases
    localparam logic [1:0] NUM_WS   = 2'd0;
    localparam logic [1:0] NUM_SIGN = 2'd1;
    localparam logic [1:0] NUM_DIG  = 2'd2;
    localparam logic [1:0] NUM_STOP = 2'd3;

    // Token phases
    localparam logic [1:0] PH_WHOLE = 2'd0;
    localparam logic [1:0] PH_FRAC  = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    localparam logic [4:0] MAX_SCALE     = 5'd18;
    localparam logic [4:0] DEF_SCALE     = 5'd2;
    localparam logic [4:0] PART_CHARS    = 5'd31;
    localparam logic [2:0] POS_SAT       = 3'd7;
    localparam logic [63:0] SAT_MAG      = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MUL_LIMIT    = 64'd922337203685477580;
    localparam logic [63:0] INT_POS_MAX  = 64'd2147483647;
    localparam logic [63:0] INT_NEG_MAX  = 64'd2147483648;
    localparam logic [31:0] ISO_YEAR_MIN = 32'd31;

    // Datetime field weights
    localparam logic [63:0] W_YEAR  = 64'd10000000000;
    localparam logic [63:0] W_MONTH = 64'd100000000;
    localparam logic [63:0] W_DAY   = 64'd1000000;
    localparam logic [63:0] W_HOUR  = 64'd10000;
    localparam logic [63:0] W_MIN   = 64'd100;

    typedef struct packed {
        logic [1:0]  ph;
        logic        neg;
        logic [63:0] mag;
    } t_num;

    // Snapshot of a finished token, handed to the result pipeline
    typedef struct packed {
        logic [2:0]       kind;
        logic             nul;
        logic             bool_hit;
        logic [63:0]      wval;
        logic [63:0]      fmag;
        logic             fneg;
        logic             fstop;
        logic [4:0]       scale;
        logic [4:0]       seen;
        logic             nsign;
        logic [5:0][31:0] fields;
    } t_snap;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    // One character into a saturating decimal reader
    function automatic t_num num_feed(input t_num cur, input logic [7:0] c);
        t_num        r;
        logic [63:0] m;
        r = cur;
        m = cur.mag;
        if (cur.ph != NUM_STOP) begin
            if (is_digit(c)) begin
                if (cur.mag > MUL_LIMIT) begin
                    m = SAT_MAG;
                end else begin
                    m = (cur.mag << 3) + (cur.mag << 1) + {56'd0, c - "0"};
                    if (m > SAT_MAG) m = SAT_MAG;
                end
                r.mag = m;
                r.ph  = NUM_DIG;
            end else if (cur.ph == NUM_WS && is_space(c)) begin
                r.ph = NUM_WS;
            end else if (cur.ph == NUM_WS && (c == "+" || c == "-")) begin
                r.neg = (c == "-");
                r.ph  = NUM_SIGN;
            end else begin
                r.ph = NUM_STOP;
            end
        end
        return r;
    endfunction

    // Signed value of a saturated magnitude
    function automatic logic [63:0] num_value(input logic neg, input logic [63:0] mag);
        if (neg) return (mag >= SAT_MAG) ? SAT_MAG : (64'd0 - mag);
        return (mag >= SAT_MAG) ? (SAT_MAG - 64'd1) : mag;
    endfunction

    // Keyword letter check: 0 NULL, 1 TRUE, 2 true, 3 "1"
    function automatic logic kw_ok(input logic [1:0] k, input logic [2:0] pos,
                                   input logic [7:0] c);
        logic [7:0] e;
        logic       v;
        e = 8'd0;
        v = 1'b1;
        case ({k, pos})
            {2'd0, 3'd0}: e = "N";
            {2'd0, 3'd1}: e = "U";
            {2'd0, 3'd2}: e = "L";
            {2'd0, 3'd3}: e = "L";
            {2'd1, 3'd0}: e = "T";
            {2'd1, 3'd1}: e = "R";
            {2'd1, 3'd2}: e = "U";
            {2'd1, 3'd3}: e = "E";
            {2'd2, 3'd0}: e = "t";
            {2'd2, 3'd1}: e = "r";
            {2'd2, 3'd2}: e = "u";
            {2'd2, 3'd3}: e = "e";
            {2'd3, 3'd0}: e = "1";
            default:      v = 1'b0;
        endcase
        return v && (c == e);
    endfunction

    function automatic logic [63:0] pow10(input logic [4:0] n);
        logic [63:0] p;
        case (n)
            5'd0:  p = 64'd1;
            5'd1:  p = 64'd10;
            5'd2:  p = 64'd100;
            5'd3:  p = 64'd1000;
            5'd4:  p = 64'd10000;
            5'd5:  p = 64'd100000;
            5'd6:  p = 64'd1000000;
            5'd7:  p = 64'd10000000;
            5'd8:  p = 64'd100000000;
            5'd9:  p = 64'd1000000000;
            5'd10: p = 64'd10000000000;
            5'd11: p = 64'd100000000000;
            5'd12: p = 64'd1000000000000;
            5'd13: p = 64'd10000000000000;
            5'd14: p = 64'd100000000000000;
            5'd15: p = 64'd1000000000000000;
            5'd16: p = 64'd10000000000000000;
            5'd17: p = 64'd100000000000000000;
            5'd18: p = 64'd1000000000000000000;
            default: p = 64'd0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== src/slt_char_parse.sv =====
// ----------------------------------------------------------------------------
// slt_char_parse
// Per-character token state: number readers, keyword match, date fields.
// Emits a token snapshot alongside the final character.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_char_parse (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_accept,
    input  wire  [7:0]          i_char,
    input  wire                 i_final,
    input  wire  [2:0]          i_col_type,
    input  wire  [4:0]          i_dec_scale,
    output slt_pkg::t_snap      o_snap
);

    logic [2:0]       r_pos, n_pos;
    logic [3:0]       r_kw, n_kw;
    logic             r_ended, n_ended;
    logic [2:0]       r_type, n_type;
    logic [4:0]       r_scale, n_scale;
    slt_pkg::t_num    r_whole, n_whole;
    slt_pkg::t_num    r_frac, n_frac;
    logic [4:0]       r_fseen, n_fseen;
    logic [1:0]       r_phase, n_phase;
    logic             r_nsign, n_nsign;
    logic [4:0]       r_part, n_part;
    logic [5:0][31:0] r_fields, n_fields;
    logic [2:0]       r_fidx, n_fidx;
    logic             r_bad, n_bad;
    logic [7:0]       r_sep, n_sep;

    logic [4:0]       sc;
    logic [2:0]       need;
    logic [2:0]       k;
    logic             sep_ok;
    slt_pkg::t_num    fed;
    logic [63:0]      fval;
    logic [63:0]      wv;
    logic [5:0][31:0] f_fields;
    logic [2:0]       f_fidx;
    logic             kw_len4;

    // next state for one character
    always_comb begin
        n_pos    = r_pos;
        n_kw     = r_kw;
        n_ended  = r_ended;
        n_type   = r_type;
        n_scale  = r_scale;
        n_whole  = r_whole;
        n_frac   = r_frac;
        n_fseen  = r_fseen;
        n_phase  = r_phase;
        n_nsign  = r_nsign;
        n_part   = r_part;
        n_fields = r_fields;
        n_fidx   = r_fidx;
        n_bad    = r_bad;
        n_sep    = r_sep;
        k        = 3'd0;
        sep_ok   = 1'b1;
        fed      = slt_pkg::num_feed(r_whole, i_char);
        fval     = slt_pkg::num_value(fed.neg, fed.mag);

        // sample config on first char
        sc = (i_dec_scale == 5'd0) ? slt_pkg::DEF_SCALE : i_dec_scale;
        if (sc > slt_pkg::MAX_SCALE) sc = slt_pkg::MAX_SCALE;
        if (r_pos == 3'd0) begin
            n_type  = i_col_type;
            n_scale = sc;
        end
        need = (n_type == slt_pkg::COL_DATE) ? 3'd3 : 3'd6;

        // keyword candidates
        for (int i = 0; i < 4; i++) begin
            if (!slt_pkg::kw_ok(2'(i), r_pos, i_char)) n_kw[i] = 1'b0;
        end

        if (!r_ended) begin
            if (i_char == 8'd0) begin
                n_ended = 1'b1;
            end else begin
                case (n_type)
                    slt_pkg::COL_INT: begin
                        n_whole = fed;
                    end
                    slt_pkg::COL_DEC: begin
                        if (r_pos == 3'd0 && (i_char == "+" || i_char == "-")) begin
                            n_nsign = (i_char == "-");
                        end else if (r_phase == slt_pkg::PH_WHOLE) begin
                            if (i_char == ".") begin
                                n_phase = slt_pkg::PH_FRAC;
                            end else if (r_part < slt_pkg::PART_CHARS) begin
                                n_part  = r_part + 5'd1;
                                n_whole = fed;
                            end
                        end else if (r_fseen < n_scale) begin
                            n_fseen = r_fseen + 5'd1;
                            n_frac  = slt_pkg::num_feed(r_frac, i_char);
                        end
                    end
                    slt_pkg::COL_DATE, slt_pkg::COL_DTIME: begin
                        if (!r_bad && r_phase != slt_pkg::PH_DONE) begin
                            n_whole = fed;
                            if (fed.ph == slt_pkg::NUM_STOP) begin
                                if (r_whole.ph != slt_pkg::NUM_DIG) begin
                                    n_bad = 1'b1;
                                end else begin
                                    for (int i = 0; i < 6; i++) begin
                                        if (r_fidx == 3'(i))
                                            n_fields[i] = fval[31:0];
                                    end
                                    k      = r_fidx + 3'd1;
                                    n_fidx = k;
                                    if (k >= need) begin
                                        n_phase = slt_pkg::PH_DONE;
                                    end else begin
                                        n_whole.ph  = slt_pkg::NUM_WS;
                                        n_whole.neg = 1'b0;
                                        n_whole.mag = 64'd0;
                                        if (n_type == slt_pkg::COL_DATE) begin
                                            if (k == 3'd1) begin
                                                sep_ok = (i_char == "-") || (i_char == "/");
                                                n_sep  = i_char;
                                            end else begin
                                                sep_ok = (i_char == r_sep);
                                            end
                                        end else if (k == 3'd3) begin
                                            // date/time gap: reader restarts on this char
                                            if (slt_pkg::is_space(i_char)) begin
                                                sep_ok = 1'b1;
                                            end else if (i_char == "+" || i_char == "-") begin
                                                n_whole.ph  = slt_pkg::NUM_SIGN;
                                                n_whole.neg = (i_char == "-");
                                            end else begin
                                                sep_ok = 1'b0;
                                            end
                                        end else begin
                                            sep_ok = (i_char == ((k < 3'd3) ? "-" : ":"));
                                        end
                                        if (!sep_ok) n_bad = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                        n_whole = r_whole;
                    end
                endcase
            end
        end

        if (r_pos < slt_pkg::POS_SAT) n_pos = r_pos + 3'd1;
    end

    // token snapshot on the final character
    always_comb begin
        wv       = slt_pkg::num_value(n_whole.neg, n_whole.mag);
        f_fields = n_fields;
        f_fidx   = n_fidx;
        if (!n_bad && n_phase != slt_pkg::PH_DONE && n_whole.ph == slt_pkg::NUM_DIG) begin
            for (int i = 0; i < 6; i++) begin
                if (n_fidx == 3'(i))
                    f_fields[i] = wv[31:0];
            end
            f_fidx = n_fidx + 3'd1;
        end
        kw_len4         = (n_pos == 3'd4);
        o_snap.kind     = n_type;
        o_snap.bool_hit = (n_kw[1] && kw_len4) || (n_kw[2] && kw_len4) ||
                          (n_kw[3] && n_pos == 3'd1);
        o_snap.wval     = wv;
        o_snap.fmag     = n_frac.mag;
        o_snap.fneg     = n_frac.neg;
        o_snap.fstop    = (n_frac.ph == slt_pkg::NUM_STOP);
        o_snap.scale    = n_scale;
        o_snap.seen     = n_fseen;
        o_snap.nsign    = n_nsign;
        o_snap.fields   = f_fields;
        case (n_type)
            slt_pkg::COL_INT:
                o_snap.nul = !(n_whole.ph == slt_pkg::NUM_DIG &&
                               (n_whole.neg ? (n_whole.mag <= slt_pkg::INT_NEG_MAX)
                                            : (n_whole.mag <= slt_pkg::INT_POS_MAX)));
            slt_pkg::COL_DEC, slt_pkg::COL_BOOL:
                o_snap.nul = 1'b0;
            slt_pkg::COL_DATE, slt_pkg::COL_DTIME:
                o_snap.nul = (f_fidx != need);
            default:
                o_snap.nul = 1'b1;
        endcase
        if (n_kw[0] && kw_len4) o_snap.nul = 1'b1;
    end

    // token state; cleared after each final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_final)) begin
            r_pos    <= 3'd0;
            r_kw     <= 4'hF;
            r_ended  <= 1'b0;
            r_type   <= slt_pkg::COL_INT;
            r_scale  <= slt_pkg::DEF_SCALE;
            r_whole  <= '0;
            r_frac   <= '0;
            r_fseen  <= 5'd0;
            r_phase  <= slt_pkg::PH_WHOLE;
            r_nsign  <= 1'b0;
            r_part   <= 5'd0;
            r_fields <= '0;
            r_fidx   <= 3'd0;
            r_bad    <= 1'b0;
            r_sep    <= 8'd0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_kw     <= n_kw;
            r_ended  <= n_ended;
            r_type   <= n_type;
            r_scale  <= n_scale;
            r_whole  <= n_whole;
            r_frac   <= n_frac;
            r_fseen  <= n_fseen;
            r_phase  <= n_phase;
            r_nsign  <= n_nsign;
            r_part   <= n_part;
            r_fields <= n_fields;
            r_fidx   <= n_fidx;
            r_bad    <= n_bad;
            r_sep    <= n_sep;
        end
    end

endmodule

`default_nettype wire

// ===== src/slt_result_pipe.sv =====
// ----------------------------------------------------------------------------
// slt_result_pipe
// Three-stage result pipeline: snapshot, partial products, final sum.
// Each stage moves when empty or when the stage after it moves.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_result_pipe (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  wire slt_pkg::t_snap i_snap,
    output logic                o_ready,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [63:0]         o_value,
    output logic                o_null
);

    typedef struct packed {
        logic [2:0]       kind;
        logic             nul;
        logic             bool_hit;
        logic [63:0]      wval;
        logic             fneg;
        logic             nsign;
        logic [63:0]      a_ll;
        logic [31:0]      a_x;
        logic [63:0]      b_ll;
        logic [31:0]      b_x;
        logic [31:0]      date;
        logic [5:0][63:0] terms;
    } t_mid;

    logic           r_v1, r_v2, r_v3;
    slt_pkg::t_snap r_s1;
    t_mid           r_s2, n_s2;
    logic [63:0]    r_val, n_val;
    logic           r_nul;
    logic           rdy1, rdy2, rdy3;

    logic [63:0]    p1, p2;
    logic [31:0]    ya, yb, yd, y_sel, d_sel;
    logic           iso;
    logic [63:0]    ra, rb, rdec;
    logic [63:0]    dt_sum;

    assign rdy3    = !r_v3 || !i_stall;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // stage 2: 32x32 partial products and date packing
    always_comb begin
        p1 = slt_pkg::pow10(r_s1.scale);
        p2 = r_s1.fstop ? 64'd1 : slt_pkg::pow10(r_s1.scale - r_s1.seen);
        n_s2.kind     = r_s1.kind;
        n_s2.nul      = r_s1.nul;
        n_s2.bool_hit = r_s1.bool_hit;
        n_s2.wval     = r_s1.wval;
        n_s2.fneg     = r_s1.fneg;
        n_s2.nsign    = r_s1.nsign;
        n_s2.a_ll     = {32'd0, r_s1.wval[31:0]} * {32'd0, p1[31:0]};
        n_s2.a_x      = (r_s1.wval[31:0] * p1[63:32]) + (r_s1.wval[63:32] * p1[31:0]);
        n_s2.b_ll     = {32'd0, r_s1.fmag[31:0]} * {32'd0, p2[31:0]};
        n_s2.b_x      = (r_s1.fmag[31:0] * p2[63:32]) + (r_s1.fmag[63:32] * p2[31:0]);

        ya    = r_s1.fields[0];
        yb    = r_s1.fields[1];
        yd    = r_s1.fields[2];
        iso   = !ya[31] && (ya > slt_pkg::ISO_YEAR_MIN);
        y_sel = iso ? ya : yd;
        d_sel = iso ? yd : ya;
        n_s2.date = (y_sel * 32'd10000) + (yb * 32'd100) + d_sel;

        // sign-extended field times weight, mod 2^64
        n_s2.terms[0] = ({32'd0, r_s1.fields[0]} * slt_pkg::W_YEAR) -
                        (r_s1.fields[0][31] ? (slt_pkg::W_YEAR << 32) : 64'd0);
        n_s2.terms[1] = ({32'd0, r_s1.fields[1]} * slt_pkg::W_MONTH) -
                        (r_s1.fields[1][31] ? (slt_pkg::W_MONTH << 32) : 64'd0);
        n_s2.terms[2] = ({32'd0, r_s1.fields[2]} * slt_pkg::W_DAY) -
                        (r_s1.fields[2][31] ? (slt_pkg::W_DAY << 32) : 64'd0);
        n_s2.terms[3] = ({32'd0, r_s1.fields[3]} * slt_pkg::W_HOUR) -
                        (r_s1.fields[3][31] ? (slt_pkg::W_HOUR << 32) : 64'd0);
        n_s2.terms[4] = ({32'd0, r_s1.fields[4]} * slt_pkg::W_MIN) -
                        (r_s1.fields[4][31] ? (slt_pkg::W_MIN << 32) : 64'd0);
        n_s2.terms[5] = {{32{r_s1.fields[5][31]}}, r_s1.fields[5]};
    end

    // stage 3: sums and type select
    always_comb begin
        ra     = r_s2.a_ll + {r_s2.a_x, 32'd0};
        rb     = r_s2.b_ll + {r_s2.b_x, 32'd0};
        rdec   = ra + (r_s2.fneg ? (64'd0 - rb) : rb);
        dt_sum = (r_s2.terms[0] + r_s2.terms[1]) + (r_s2.terms[2] + r_s2.terms[3]) +
                 (r_s2.terms[4] + r_s2.terms[5]);
        case (r_s2.kind)
            slt_pkg::COL_INT:   n_val = r_s2.wval;
            slt_pkg::COL_DEC:   n_val = r_s2.nsign ? (64'd0 - rdec) : rdec;
            slt_pkg::COL_BOOL:  n_val = {63'd0, r_s2.bool_hit};
            slt_pkg::COL_DATE:  n_val = {{32{r_s2.date[31]}}, r_s2.date};
            slt_pkg::COL_DTIME: n_val = dt_sum;
            default:            n_val = 64'd0;
        endcase
        if (r_s2.nul) n_val = 64'd0;
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) r_s1 <= i_snap;
        if (rdy2 && r_v1)    r_s2 <= n_s2;
        if (rdy3 && r_v2) begin
            r_val <= n_val;
            r_nul <= r_s2.nul;
        end
    end

    assign o_valid = r_v3;
    assign o_value = r_val;
    assign o_null  = r_nul;

endmodule

`default_nettype wire

// ===== src/sql_literal_to_typed_value_top.sv =====
// ----------------------------------------------------------------------------
// sql_literal_to_typed_value_top
// Parses an SQL literal, one character per beat, into a 64-bit typed value.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | sink      | i_in_valid / o_in_stall   | i_text_char, i_is_final
//  out     | source    | o_out_valid / i_out_stall | o_typed_value, o_null_flag
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One character per cycle while o_in_stall is low; token state updates in
//  the cycle a beat is taken. o_out_valid rises once the final character has
//  passed the snapshot, partial-product and sum stages of the result pipeline.
//  Reset is synchronous; the config port is always ready.
//  An output stall backs up the three result stages before the input stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_literal_to_typed_value_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_text_char,
    input  wire         i_is_final,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [63:0] o_typed_value,
    output logic        o_null_flag,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [7:0]  i_cfg_data
);

    logic [2:0]     r_col_type;
    logic [4:0]     r_dec_scale;
    logic           accept;
    logic           pipe_ready;
    slt_pkg::t_snap snap;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !pipe_ready;
    assign accept      = i_in_valid && pipe_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_type  <= slt_pkg::COL_INT;
            r_dec_scale <= 5'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                slt_pkg::CFG_COL_TYPE:  r_col_type  <= i_cfg_data[2:0];
                slt_pkg::CFG_DEC_SCALE: r_dec_scale <= i_cfg_data[4:0];
                default: r_col_type <= r_col_type;
            endcase
        end
    end

    slt_char_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char      (i_text_char),
        .i_final     (i_is_final),
        .i_col_type  (r_col_type),
        .i_dec_scale (r_dec_scale),
        .o_snap      (snap)
    );

    slt_result_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept && i_is_final),
        .i_snap  (snap),
        .o_ready (pipe_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_value (o_typed_value),
        .o_null  (o_null_flag)
    );

endmodule

`default_nettype wire

// ===== src/slt_checker.sv =====
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks for the SQL literal parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_in_stall,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [63:0] o_typed_value,
    input wire        o_null_flag
);

    // a null result carries a zero value
    a_null_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_null_flag || o_typed_value == 64'd0))
        else $error("null result with nonzero value");

    // reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // an empty output side never stalls the input
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_typed_value) && $stable(o_null_flag)))
        else $error("stalled result changed");

endmodule

bind sql_literal_to_typed_value_top slt_checker u_slt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_typed_value (o_typed_value),
    .o_null_flag   (o_null_flag)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SQL literal parser: random and directed tokens
// per column type, an in-bench parser predicts each result and a scoreboard
// compares every output beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

// Parser predictor and result queue
class literal_scoreboard;
    logic [2:0]  col_type;
    logic [4:0]  dec_scale;
    logic [63:0] exp_val[$];
    logic        exp_nul[$];
    int          errors;

    logic [1:0]  phase;
    logic        nsign;
    logic [1:0]  w_ph, f_ph;
    logic        w_neg, f_neg;
    logic [63:0] w_mag, f_mag;
    logic [4:0]  f_seen;
    logic [31:0] flds[6];
    logic [2:0]  fidx;
    logic [3:0]  kwm;
    logic        bad;
    logic [4:0]  parts;
    logic [2:0]  pos;
    logic [2:0]  t_type;
    logic [4:0]  t_scale;
    logic        ended;
    logic [7:0]  sep;

    function new();
        col_type = slt_pkg::COL_INT;
        dec_scale = 0;
        errors = 0;
        clear_token();
    endfunction

    function void clear_token();
        phase = slt_pkg::PH_WHOLE; nsign = 0; w_ph = slt_pkg::NUM_WS;
        f_ph = slt_pkg::NUM_WS;
        w_neg = 0; f_neg = 0; w_mag = 0; f_mag = 0; f_seen = 0;
        foreach (flds[i]) flds[i] = 0;
        fidx = 0; kwm = 4'hF; bad = 0; parts = 0; pos = 0;
        t_type = slt_pkg::COL_INT; t_scale = 2; ended = 0; sep = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] d);
        if (idx == slt_pkg::CFG_COL_TYPE) col_type = d[2:0];
        else dec_scale = d[4:0];
    endfunction

    static function bit sp(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    static function void digit_feed(ref logic [1:0] ph, ref logic neg,
                                    ref logic [63:0] mag, input logic [7:0] c);
        logic [63:0] m;
        if (ph == slt_pkg::NUM_STOP) return;
        if (c >= "0" && c <= "9") begin
            if (mag > 64'd922337203685477580) m = 64'h8000_0000_0000_0000;
            else begin
                m = mag * 10 + (c - 8'd48);
                if (m > 64'h8000_0000_0000_0000) m = 64'h8000_0000_0000_0000;
            end
            mag = m;
            ph = slt_pkg::NUM_DIG;
        end else if (ph == slt_pkg::NUM_WS && sp(c)) begin
        end else if (ph == slt_pkg::NUM_WS && (c == "+" || c == "-")) begin
            neg = (c == "-");
            ph = slt_pkg::NUM_SIGN;
        end else ph = slt_pkg::NUM_STOP;
    endfunction

    static function logic [63:0] signed_of(logic neg, logic [63:0] m);
        if (neg) return (m >= 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : -m;
        return (m >= 64'h8000_0000_0000_0000) ? 64'h7FFF_FFFF_FFFF_FFFF : m;
    endfunction

    static function logic [63:0] ten_pow(int n);
        logic [63:0] p;
        p = 1;
        for (int i = 0; i < n; i++) p = p * 10;
        return p;
    endfunction

    function void date_step(logic [7:0] c);
        logic [2:0] need, k;
        logic [1:0] prev;
        bit ok;
        need = (t_type == slt_pkg::COL_DATE) ? 3 : 6;
        if (bad || phase == slt_pkg::PH_DONE) return;
        prev = w_ph;
        digit_feed(w_ph, w_neg, w_mag, c);
        if (w_ph != slt_pkg::NUM_STOP) return;
        if (prev != slt_pkg::NUM_DIG) begin bad = 1; return; end
        if (fidx < 6) flds[fidx] = signed_of(w_neg, w_mag);
        fidx++;
        if (fidx >= need) begin phase = slt_pkg::PH_DONE; return; end
        k = fidx;
        w_ph = slt_pkg::NUM_WS; w_neg = 0; w_mag = 0;
        if (t_type == slt_pkg::COL_DATE) begin
            if (k == 1) begin ok = (c == "-" || c == "/"); sep = c; end
            else ok = (c == sep);
        end else if (k == 3) begin
            digit_feed(w_ph, w_neg, w_mag, c);
            ok = (w_ph != slt_pkg::NUM_STOP);
        end else ok = (c == ((k < 3) ? "-" : ":"));
        if (!ok) bad = 1;
    endfunction

    function bit kw_hit(int k);
        int len;
        len = (k == 3) ? 1 : 4;
        return kwm[k] && pos == len;
    endfunction

    // Accepted input beat: update parse state, queue a result on final
    function void note_char(logic [7:0] c, logic fin);
        string kw[4];
        logic [63:0] v, ip, fm, r;
        logic nul;
        logic [2:0] need;
        logic [31:0] a, b, d, y, dd;
        bit iso;
        kw[0] = "NULL"; kw[1] = "TRUE"; kw[2] = "true"; kw[3] = "1";
        v = 0; nul = 0;
        if (pos == 0) begin
            t_type = col_type;
            t_scale = (dec_scale == 0) ? 2 : (dec_scale > 18 ? 18 : dec_scale);
        end
        for (int k = 0; k < 4; k++)
            if (!(pos < kw[k].len() && c == kw[k][pos])) kwm[k] = 0;
        if (!ended) begin
            if (c == 0) ended = 1;
            else case (t_type)
                slt_pkg::COL_INT: digit_feed(w_ph, w_neg, w_mag, c);
                slt_pkg::COL_DEC: begin
                    if (pos == 0 && (c == "+" || c == "-")) nsign = (c == "-");
                    else if (phase == slt_pkg::PH_WHOLE) begin
                        if (c == ".") phase = slt_pkg::PH_FRAC;
                        else if (parts < 31) begin
                            parts++;
                            digit_feed(w_ph, w_neg, w_mag, c);
                        end
                    end else if (f_seen < t_scale) begin
                        f_seen++;
                        digit_feed(f_ph, f_neg, f_mag, c);
                    end
                end
                slt_pkg::COL_DATE, slt_pkg::COL_DTIME: date_step(c);
                default: ;
            endcase
        end
        if (pos < 7) pos++;
        if (!fin) return;
        if (kw_hit(0)) nul = 1;
        else case (t_type)
            slt_pkg::COL_INT:
                if (w_ph == slt_pkg::NUM_DIG && (w_neg ? w_mag <= 64'd2147483648
                                                       : w_mag <= 64'd2147483647))
                    v = signed_of(w_neg, w_mag);
                else nul = 1;
            slt_pkg::COL_DEC: begin
                ip = signed_of(w_neg, w_mag);
                fm = f_mag;
                if (f_ph != slt_pkg::NUM_STOP) fm = fm * ten_pow(t_scale - f_seen);
                r = ip * ten_pow(t_scale) + (f_neg ? -fm : fm);
                v = nsign ? -r : r;
            end
            slt_pkg::COL_BOOL: v = (kw_hit(1) || kw_hit(2) || kw_hit(3)) ? 1 : 0;
            slt_pkg::COL_DATE, slt_pkg::COL_DTIME: begin
                need = (t_type == slt_pkg::COL_DATE) ? 3 : 6;
                if (!bad && phase != slt_pkg::PH_DONE && w_ph == slt_pkg::NUM_DIG) begin
                    if (fidx < 6) flds[fidx] = signed_of(w_neg, w_mag);
                    fidx++;
                end
                if (fidx != need) nul = 1;
                else if (t_type == slt_pkg::COL_DATE) begin
                    a = flds[0]; b = flds[1]; d = flds[2];
                    iso = !a[31] && a > 31;
                    y = iso ? a : d;
                    dd = iso ? d : a;
                    v = {{32{1'b0}}, 32'(y * 10000 + b * 100 + dd)};
                    v = {{32{v[31]}}, v[31:0]};
                end else
                    v = {{32{flds[0][31]}}, flds[0]} * 64'd10000000000
                      + {{32{flds[1][31]}}, flds[1]} * 64'd100000000
                      + {{32{flds[2][31]}}, flds[2]} * 64'd1000000
                      + {{32{flds[3][31]}}, flds[3]} * 64'd10000
                      + {{32{flds[4][31]}}, flds[4]} * 64'd100
                      + {{32{flds[5][31]}}, flds[5]};
            end
            default: nul = 1;
        endcase
        exp_val.push_back(nul ? 64'd0 : v);
        exp_nul.push_back(nul);
        clear_token();
    endfunction

    // Output beat against the oldest expectation
    function void check_result(logic [63:0] v, logic n);
        logic [63:0] ev;
        logic en;
        if (exp_val.size() == 0) begin
            $error("unexpected result beat value=%h null=%b", v, n);
            errors++;
            return;
        end
        ev = exp_val.pop_front();
        en = exp_nul.pop_front();
        if (v !== ev) begin
            $error("typed_value expected %h actual %h", ev, v);
            errors++;
        end
        if (n !== en) begin
            $error("null_flag expected %b actual %b", en, n);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_text_char;
    logic        i_is_final;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_typed_value;
    logic        o_null_flag;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;

    literal_scoreboard sb;
    int  cycle_cnt;
    bit  quiet_window;
    bit  hold_off;

    sql_literal_to_typed_value_top dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > 600000) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Accept and check output beats
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_typed_value, o_null_flag);
    end

    // Receiver stall pattern
    initial begin
        i_out_stall = 0;
        forever begin
            @(negedge i_clk);
            i_out_stall <= hold_off ? 1'b1 :
                           (!quiet_window && $urandom_range(0, 99) < 15);
        end
    end

    // valid stays up after the last beat until the next char, idle or drain
    task automatic send_char(logic [7:0] c, logic fin);
        while (!quiet_window && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_in_valid <= 1;
        i_text_char <= c;
        i_is_final <= fin;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_char(c, fin);
        @(negedge i_clk);
    endtask

    task automatic send_token(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic write_reg(logic idx, logic [7:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, d);
        @(negedge i_clk);
        i_cfg_valid <= 0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.exp_val.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic string rand_digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'(48 + $urandom_range(0, 9)))};
        return s;
    endfunction

    // Well-formed token for a type with occasional damage
    function automatic string make_token(logic [2:0] t);
        string s, sp;
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return "NULL";
        sp = ($urandom_range(0, 3) == 0) ? "-" : "/";
        case (t)
            slt_pkg::COL_INT: s = {($urandom_range(0, 2) == 0) ? "-" : "",
                                   rand_digits($urandom_range(1, 11))};
            slt_pkg::COL_DEC: s = {($urandom_range(0, 2) == 0) ? "-" : "",
                                   rand_digits($urandom_range(0, 8)), ".",
                                   rand_digits($urandom_range(0, 20))};
            slt_pkg::COL_BOOL: case ($urandom_range(0, 4))
                0: s = "TRUE"; 1: s = "true"; 2: s = "1"; 3: s = "0";
                default: s = "TRUX";
            endcase
            slt_pkg::COL_DATE: s = ($urandom_range(0, 1)) ?
                {rand_digits(4), sp, rand_digits(2), sp, rand_digits(2)} :
                {rand_digits(2), sp, rand_digits(2), sp, rand_digits(4)};
            default: s = {rand_digits(4), "-", rand_digits(2), "-", rand_digits(2),
                          " ", rand_digits(2), ":", rand_digits(2), ":",
                          rand_digits($urandom_range(1, 3))};
        endcase
        if (r > 85 && s.len() > 1) s[$urandom_range(0, s.len() - 1)] =
            8'($urandom_range(0, 255));
        if (r > 95) s = {s, " x"};
        return s;
    endfunction

    task automatic random_chars(int n);
        for (int i = 0; i < n; i++)
            send_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        send_char(8'($urandom_range(0, 255)), 1);
    endtask

    initial begin
        string tok;
        int    sent;
        logic [2:0] t;
        sb = new();
        i_rst_n = 0;
        i_in_valid = 0;
        i_text_char = 0;
        i_is_final = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        quiet_window = 0;
        hold_off = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: keywords, extremes, each type
        write_reg(slt_pkg::CFG_COL_TYPE, slt_pkg::COL_INT);
        write_reg(slt_pkg::CFG_DEC_SCALE, 0);
        send_token("NULL");
        send_token(" -2147483648");
        send_token("2147483648");
        send_token("+12a");
        drain();
        write_reg(slt_pkg::CFG_COL_TYPE, slt_pkg::COL_DEC);
        send_token("-12.3456");
        send_token("99999999999999999999.5");
        drain();
        write_reg(slt_pkg::CFG_DEC_SCALE, 31);
        send_token("1.25");
        drain();
        write_reg(slt_pkg::CFG_COL_TYPE, slt_pkg::COL_BOOL);
        send_token("true");
        send_token("TRUE");
        send_token("1");
        send_token("NUL");
        drain();
        write_reg(slt_pkg::CFG_COL_TYPE, slt_pkg::COL_DATE);
        send_token("2024-01-15");
        send_token("15/01/2024");
        send_token("15/01-2024");
        send_char(8'hFF, 0);
        send_char(8'h00, 1);
        drain();
        write_reg(slt_pkg::CFG_COL_TYPE, slt_pkg::COL_DTIME);
        send_token("2024-01-15 10:20:30");
        send_token("2024-01-15");
        drain();
        write_reg(slt_pkg::CFG_COL_TYPE, 3'd7);
        send_token("5");
        drain();

        // Random phases across settings
        sent = 0;
        for (int ph = 0; ph < 12; ph++) begin
            t = (ph < 10) ? 3'(ph % 5) : 3'($urandom_range(5, 7));
            write_reg(slt_pkg::CFG_COL_TYPE,
                      $urandom_range(0, 1) ? 8'(t) : {5'($urandom), t});
            write_reg(slt_pkg::CFG_DEC_SCALE, (ph == 3) ? 8'd18 : (ph == 8) ? 8'd1 :
                                              8'($urandom_range(0, 255)));
            quiet_window = (ph == 5);
            if (ph == 2) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(negedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int k = 0; k < 13; k++) begin
                if ($urandom_range(0, 9) == 0) random_chars($urandom_range(0, 6));
                else send_token(make_token(t));
            end
            drain();
        end
        quiet_window = 0;
        drain();
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.exp_val.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

`default_nettype wire
